// ===== rtl/oid_tn_pkg.sv =====
package oid_tn_pkg;

  localparam int SMALL_ENTRIES_DEF = 1024;
  localparam int BIG_ENTRIES_DEF   = 1024;
  localparam int ROOT_COUNT        = 3;
  localparam int LINEAR_LIMIT      = 6;
  localparam int KEY_W             = 32;
  localparam int LINK_W            = 46;
  localparam int ENTRY_W           = KEY_W + LINK_W;

  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_WR_SMALL = 2'd1,
    OP_WR_BIG   = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [7:0]  name_length;
    logic [15:0] name_offset;
    logic        child_in_big;
    logic [10:0] child_count;
    logic [9:0]  child_start;
  } link_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    link_t            link;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [9:0]       range_start;
    logic [10:0]      range_count;
    logic             range_in_big;
  } srch_req_t;

  typedef struct packed {
    logic  done;
    logic  hit;
    link_t link;
  } srch_rsp_t;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_ISSUE,
    SR_CMP,
    SR_MISS
  } srch_state_e;

  typedef enum logic [1:0] {
    TP_IDLE,
    TP_SEARCH,
    TP_DELIVER
  } top_state_e;

endpackage

// ===== rtl/oid_tn_ram.sv =====
module oid_tn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/oid_tn_search.sv =====
module oid_tn_search
  import oid_tn_pkg::*;
#(
  parameter int SMALL_ENTRIES = SMALL_ENTRIES_DEF,
  parameter int BIG_ENTRIES   = BIG_ENTRIES_DEF,
  parameter int SAW = (SMALL_ENTRIES > 1) ? $clog2(SMALL_ENTRIES) : 1,
  parameter int BAW = (BIG_ENTRIES > 1) ? $clog2(BIG_ENTRIES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  srch_req_t              req_i,
  output srch_rsp_t              rsp_o,
  output logic                   rd_en_o,
  output logic [SAW-1:0]         small_raddr_o,
  output logic [BAW-1:0]         big_raddr_o,
  input  logic [ENTRY_W-1:0]     small_rdata_i,
  input  logic [ENTRY_W-1:0]     big_rdata_i
);

  localparam int SW  = $clog2(SMALL_ENTRIES + 1);
  localparam int BW  = $clog2(BIG_ENTRIES + 1);
  localparam int MW  = (SW > BW) ? SW : BW;
  localparam int IW  = (MW > 11) ? MW : 11;

  srch_state_e      state_q, state_d;
  logic [IW-1:0]    lo_q, lo_d, end_q, end_d, probe_q, probe_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             in_big_q, in_big_d, binary_q, binary_d;

  logic [IW-1:0]    start_x, cnt_x, size_x, avail, clip, mid, probe_inc;
  entry_t           entry;

  always_comb begin
    start_x   = IW'(req_i.range_start);
    cnt_x     = IW'(req_i.range_count);
    size_x    = req_i.range_in_big ? IW'(BIG_ENTRIES) : IW'(SMALL_ENTRIES);
    avail     = size_x - start_x;
    if (start_x >= size_x) begin
      clip = '0;
    end else if (cnt_x > avail) begin
      clip = avail;
    end else begin
      clip = cnt_x;
    end
    mid       = lo_q + ((end_q - lo_q) >> 1);
    probe_inc = probe_q + IW'(1);
    entry     = in_big_q ? entry_t'(big_rdata_i) : entry_t'(small_rdata_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SR_IDLE: begin
        if (req_i.start) begin
          state_d = (clip == '0) ? SR_MISS : SR_ISSUE;
        end
      end
      SR_ISSUE: state_d = SR_CMP;
      SR_CMP: begin
        if (entry.key == key_q) begin
          state_d = SR_IDLE;
        end else if (entry.key < key_q) begin
          state_d = (probe_inc >= end_q) ? SR_IDLE : SR_ISSUE;
        end else if (!binary_q || probe_q <= lo_q) begin
          state_d = SR_IDLE;
        end else begin
          state_d = SR_ISSUE;
        end
      end
      SR_MISS: state_d = SR_IDLE;
      default: state_d = SR_IDLE;
    endcase
  end

  always_comb begin
    lo_d          = lo_q;
    end_d         = end_q;
    probe_d       = probe_q;
    key_d         = key_q;
    in_big_d      = in_big_q;
    binary_d      = binary_q;
    rd_en_o       = 1'b0;
    rsp_o         = '0;
    rsp_o.link    = entry.link;
    case (state_q)
      SR_IDLE: begin
        if (req_i.start) begin
          lo_d     = start_x;
          end_d    = start_x + clip;
          key_d    = req_i.key;
          in_big_d = req_i.range_in_big;
          binary_d = !req_i.range_in_big && (clip >= IW'(LINEAR_LIMIT));
        end
      end
      SR_ISSUE: begin
        probe_d = binary_q ? mid : lo_q;
        rd_en_o = 1'b1;
      end
      SR_CMP: begin
        if (entry.key == key_q) begin
          rsp_o.done = 1'b1;
          rsp_o.hit  = 1'b1;
        end else if (entry.key < key_q) begin
          lo_d       = probe_inc;
          rsp_o.done = (probe_inc >= end_q);
        end else if (!binary_q || probe_q <= lo_q) begin
          rsp_o.done = 1'b1;
        end else begin
          end_d = probe_q;
        end
      end
      SR_MISS: rsp_o.done = 1'b1;
      default: ;
    endcase
  end

  assign small_raddr_o = probe_d[SAW-1:0];
  assign big_raddr_o   = probe_d[BAW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    end_q    <= end_d;
    probe_q  <= probe_d;
    key_q    <= key_d;
    in_big_q <= in_big_d;
    binary_q <= binary_d;
  end

  ap_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SR_CMP |-> (probe_q >= lo_q) && (probe_q < end_q))
    else $error("probe outside search range");

  ap_issue_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SR_ISSUE |-> lo_q < end_q)
    else $error("probe issued on empty range");

  ap_small_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SR_CMP && !in_big_q) |-> end_q <= IW'(SMALL_ENTRIES))
    else $error("small table range beyond table");

  ap_big_linear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SR_CMP && in_big_q) |-> !binary_q)
    else $error("big table range searched by halving");

endmodule

// ===== rtl/oid_tree_name_lookup.sv =====
// Channel | Handshake                 | Payload
// in      | in_valid_i / in_stall_o   | opcode_i .. last_component_i
// out     | out_valid_o / out_stall_i | status_o, name_offset_o, name_length_o
//
// A write item, or a component after the walk failed, needs no table search. A searched
// component with an empty range ends in the miss state without a table read; otherwise
// it runs probes in turn, each probe one table read plus one key compare.
// Probes: up to the range length for linear ranges, about log2(range length) + 1 for binary.
// A final component then waits in the deliver state until the output can take the result.
// Reset restores the root range and clears the failed flag; tables hold no reset value.
// in_stall_o stays high while a component is searched or a result waits for the output.
module oid_tree_name_lookup
  import oid_tn_pkg::*;
#(
  parameter int SMALL_ENTRIES = SMALL_ENTRIES_DEF,
  parameter int BIG_ENTRIES   = BIG_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] key_value_i,
  input  logic [9:0]  child_start_i,
  input  logic [10:0] child_count_i,
  input  logic        child_in_big_i,
  input  logic [15:0] name_offset_in_i,
  input  logic [7:0]  name_length_in_i,
  input  logic        last_component_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [15:0] name_offset_o,
  output logic [7:0]  name_length_o
);

  localparam int SAW = (SMALL_ENTRIES > 1) ? $clog2(SMALL_ENTRIES) : 1;
  localparam int BAW = (BIG_ENTRIES > 1) ? $clog2(BIG_ENTRIES) : 1;
  localparam int SW  = $clog2(SMALL_ENTRIES + 1);
  localparam int BW  = $clog2(BIG_ENTRIES + 1);
  localparam int MW  = (SW > BW) ? SW : BW;
  localparam int XW  = (MW > 11) ? MW : 11;

  top_state_e     state_q, state_d;
  logic [9:0]     range_start_q;
  logic [10:0]    range_count_q;
  logic           range_in_big_q, walk_failed_q;
  logic           last_q;
  logic           res_found_q;
  link_t          res_link_q;
  logic           out_valid_q, status_q;
  logic [15:0]    name_offset_q;
  logic [7:0]     name_length_q;

  logic           accept, is_lookup, out_free, out_load;
  logic           small_we, big_we, rd_en;
  logic [XW-1:0]  idx_x;
  logic [SAW-1:0] small_raddr;
  logic [BAW-1:0] big_raddr;
  logic [ENTRY_W-1:0] small_rdata, big_rdata;
  entry_t         wr_entry;
  srch_req_t      req;
  srch_rsp_t      rsp;

  assign accept    = in_valid_i && !in_stall_o;
  assign is_lookup = (opcode_i == OP_LOOKUP);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign idx_x     = XW'(entry_index_i);

  always_comb begin
    wr_entry.key               = key_value_i;
    wr_entry.link.child_start  = child_start_i;
    wr_entry.link.child_count  = child_count_i;
    wr_entry.link.child_in_big = child_in_big_i;
    wr_entry.link.name_offset  = name_offset_in_i;
    wr_entry.link.name_length  = name_length_in_i;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      TP_IDLE: begin
        if (accept && is_lookup) begin
          if (!walk_failed_q) begin
            state_d = TP_SEARCH;
          end else if (last_component_i) begin
            state_d = TP_DELIVER;
          end
        end
      end
      TP_SEARCH: begin
        if (rsp.done) begin
          state_d = last_q ? TP_DELIVER : TP_IDLE;
        end
      end
      TP_DELIVER: begin
        if (out_free) begin
          state_d = TP_IDLE;
        end
      end
      default: state_d = TP_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o       = (state_q != TP_IDLE);
    small_we         = 1'b0;
    big_we           = 1'b0;
    out_load         = 1'b0;
    req.start        = 1'b0;
    req.key          = key_value_i;
    req.range_start  = range_start_q;
    req.range_count  = range_count_q;
    req.range_in_big = range_in_big_q;
    case (state_q)
      TP_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_LOOKUP:   req.start = !walk_failed_q;
            OP_WR_SMALL: small_we  = (idx_x < XW'(SMALL_ENTRIES));
            OP_WR_BIG:   big_we    = (idx_x < XW'(BIG_ENTRIES));
            default:     ;
          endcase
        end
      end
      TP_DELIVER: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= TP_IDLE;
      range_start_q  <= '0;
      range_count_q  <= 11'(ROOT_COUNT);
      range_in_big_q <= 1'b0;
      walk_failed_q  <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == TP_SEARCH && rsp.done && !last_q) begin
        if (!rsp.hit || rsp.link.child_count == '0) begin
          walk_failed_q <= 1'b1;
        end else begin
          range_start_q  <= rsp.link.child_start;
          range_count_q  <= rsp.link.child_count;
          range_in_big_q <= rsp.link.child_in_big;
        end
      end
      if (out_load) begin
        range_start_q  <= '0;
        range_count_q  <= 11'(ROOT_COUNT);
        range_in_big_q <= 1'b0;
        walk_failed_q  <= 1'b0;
        out_valid_q    <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_lookup) begin
      last_q      <= last_component_i;
      res_found_q <= 1'b0;
    end
    if (state_q == TP_SEARCH && rsp.done) begin
      res_found_q <= rsp.hit;
      res_link_q  <= rsp.link;
    end
    if (out_load) begin
      status_q      <= !res_found_q;
      name_offset_q <= res_found_q ? res_link_q.name_offset : '0;
      name_length_q <= res_found_q ? res_link_q.name_length : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign name_offset_o = name_offset_q;
  assign name_length_o = name_length_q;

  oid_tn_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SMALL_ENTRIES),
    .AW    (SAW)
  ) u_small_ram (
    .clk_i   (clk_i),
    .we_i    (small_we),
    .waddr_i (idx_x[SAW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (small_raddr),
    .rdata_o (small_rdata)
  );

  oid_tn_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BIG_ENTRIES),
    .AW    (BAW)
  ) u_big_ram (
    .clk_i   (clk_i),
    .we_i    (big_we),
    .waddr_i (idx_x[BAW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (big_raddr),
    .rdata_o (big_rdata)
  );

  oid_tn_search #(
    .SMALL_ENTRIES (SMALL_ENTRIES),
    .BIG_ENTRIES   (BIG_ENTRIES),
    .SAW           (SAW),
    .BAW           (BAW)
  ) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .rsp_o         (rsp),
    .rd_en_o       (rd_en),
    .small_raddr_o (small_raddr),
    .big_raddr_o   (big_raddr),
    .small_rdata_i (small_rdata),
    .big_rdata_i   (big_rdata)
  );

  ap_done_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == TP_SEARCH)
    else $error("search finished outside a lookup");

  ap_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == TP_DELIVER))
    else $error("result loaded without delivery");

  ap_walk_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (range_count_q == 11'(ROOT_COUNT)) && !walk_failed_q && !range_in_big_q)
    else $error("walk not restarted after result");

  ap_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (small_we || big_we) |-> (state_q == TP_IDLE) && !rd_en)
    else $error("table write during search");

endmodule

// ===== test/oid_tree_name_lookup_tb.sv =====
module oid_tree_name_lookup_tb
  import oid_tn_pkg::*;
();

  localparam int SMALL_N = SMALL_ENTRIES_DEF;
  localparam int BIG_N = BIG_ENTRIES_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic ST_FOUND = 1'b0;
  localparam logic ST_NOT_FOUND = 1'b1;
  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS = 575;
  localparam int PHASE_ITEMS = 192;
  localparam int FILL_CAP = 32;
  localparam int HOLD_OFF_CYCLES = 240;
  localparam int DRAIN_CYCLES = 2100;
  localparam int CYCLE_LIMIT = 10_000_000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  index;
    logic [31:0] key;
    logic [9:0]  cstart;
    logic [10:0] ccount;
    logic        cbig;
    logic [15:0] noff;
    logic [7:0]  nlen;
    logic        last;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] name_offset;
    logic [7:0]  name_length;
  } name_result_t;

  typedef struct packed {
    item_t        it;
    logic         typed;
    name_result_t res;
  } dir_row_t;

  localparam name_result_t NO_NAME = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [9:0]  entry_index_i = '0;
  logic [31:0] key_value_i = '0;
  logic [9:0]  child_start_i = '0;
  logic [10:0] child_count_i = '0;
  logic        child_in_big_i = 1'b0;
  logic [15:0] name_offset_in_i = '0;
  logic [7:0]  name_length_in_i = '0;
  logic        last_component_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        status_o;
  logic [15:0] name_offset_o;
  logic [7:0]  name_length_o;

  logic [31:0] small_keys [SMALL_N];
  link_t       small_links [SMALL_N];
  bit          small_written [SMALL_N];
  logic [31:0] big_keys [BIG_N];
  link_t       big_links [BIG_N];
  bit          big_written [BIG_N];
  logic [9:0]  walk_start = '0;
  logic [10:0] walk_count = 11'(ROOT_COUNT);
  logic        walk_in_big = 1'b0;
  logic        walk_failed = 1'b0;

  name_result_t pending_names [$];
  name_result_t oldest_name;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_left = 0;
  int error_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int lookups_sent = 0;
  int writes_sent = 0;
  int results_seen = 0;

  dir_row_t dir_rows [DIRECTED_ITEMS] = '{
    '{'{OP_WR_SMALL, 10'd0, 32'd0, 10'd3, 11'd2, 1'b0, 16'd0, 8'd0, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_WR_SMALL, 10'd1, 32'd1, 10'd0, 11'd1, 1'b1, 16'hFFFF, 8'hFF, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_WR_SMALL, 10'd2, 32'd2, 10'd5, 11'd0, 1'b0, 16'd100, 8'd5, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_WR_SMALL, 10'd3, 32'd10, 10'd0, 11'd0, 1'b0, 16'd200, 8'd3, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_WR_SMALL, 10'd4, 32'hFFFF_FFFF, 10'd1023, 11'd1024, 1'b0, 16'd300, 8'd7, 1'b0},
      1'b0, NO_NAME},
    '{'{OP_WR_SMALL, 10'd1023, 32'd7, 10'd0, 11'd0, 1'b0, 16'd400, 8'd9, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_WR_BIG, 10'd0, 32'd5, 10'd1023, 11'd1024, 1'b1, 16'd500, 8'd11, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_WR_BIG, 10'd1023, 32'd9, 10'd0, 11'd0, 1'b0, 16'd600, 8'd13, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 10'h3FF, 11'd1024, 1'b1, 16'hFFFF, 8'hFF, 1'b1},
      1'b0, NO_NAME},
    '{'{OP_LOOKUP, 10'd0, 32'd2, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b1},
      1'b1, '{ST_FOUND, 16'd100, 8'd5}},
    '{'{OP_LOOKUP, 10'd0, 32'd0, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_LOOKUP, 10'd0, 32'd10, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b1},
      1'b1, '{ST_FOUND, 16'd200, 8'd3}},
    '{'{OP_LOOKUP, 10'd0, 32'd0, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_LOOKUP, 10'd0, 32'hFFFF_FFFF, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_LOOKUP, 10'd0, 32'd7, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b1},
      1'b1, '{ST_FOUND, 16'd400, 8'd9}},
    '{'{OP_LOOKUP, 10'd0, 32'd1, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_LOOKUP, 10'd0, 32'd5, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_LOOKUP, 10'd0, 32'd9, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b1},
      1'b1, '{ST_FOUND, 16'd600, 8'd13}},
    '{'{OP_LOOKUP, 10'd0, 32'd3, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b1},
      1'b1, '{ST_NOT_FOUND, 16'd0, 8'd0}},
    '{'{OP_LOOKUP, 10'd0, 32'd2, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_LOOKUP, 10'd0, 32'd0, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b1},
      1'b1, '{ST_NOT_FOUND, 16'd0, 8'd0}},
    '{'{OP_LOOKUP, 10'd0, 32'd0, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_LOOKUP, 10'd0, 32'd11, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b0}, 1'b0, NO_NAME},
    '{'{OP_LOOKUP, 10'd0, 32'd0, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b1},
      1'b1, '{ST_NOT_FOUND, 16'd0, 8'd0}},
    '{'{OP_LOOKUP, 10'd0, 32'd0, 10'd0, 11'd0, 1'b0, 16'd0, 8'd0, 1'b1},
      1'b1, '{ST_FOUND, 16'd0, 8'd0}}
  };

  oid_tree_name_lookup dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int range_length();
    int lim;
    int n;
    lim = walk_in_big ? BIG_N : SMALL_N;
    n = int'(walk_count);
    if (n > lim - int'(walk_start)) n = lim - int'(walk_start);
    return n;
  endfunction

  // Return the matching index or -1; gap names the first unwritten entry the search reads.
  function automatic int search_range(input logic [31:0] key, output int gap);
    int n;
    int lo;
    int hi;
    int mid;
    logic [31:0] k;
    gap = -1;
    n = range_length();
    if (!walk_in_big && n >= LINEAR_LIMIT) begin
      lo = int'(walk_start);
      hi = lo + n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (!small_written[mid]) begin
          gap = mid;
          return -1;
        end
        k = small_keys[mid];
        if (k == key) return mid;
        if (k < key) lo = mid + 1;
        else hi = mid;
      end
      return -1;
    end
    for (int i = int'(walk_start); i < int'(walk_start) + n; i++) begin
      if (!(walk_in_big ? big_written[i] : small_written[i])) begin
        gap = i;
        return -1;
      end
      k = walk_in_big ? big_keys[i] : small_keys[i];
      if (k >= key) return (k == key) ? i : -1;
    end
    return -1;
  endfunction

  function automatic bit walk_component(input logic [31:0] key, input logic last,
                                        output name_result_t res);
    int hit;
    int gap;
    link_t lk;
    hit = -1;
    lk = '0;
    res = '0;
    if (!walk_failed) begin
      hit = search_range(key, gap);
      if (hit >= 0) lk = walk_in_big ? big_links[hit] : small_links[hit];
    end
    if (last) begin
      res.status = (hit >= 0) ? ST_FOUND : ST_NOT_FOUND;
      if (hit >= 0) begin
        res.name_offset = lk.name_offset;
        res.name_length = lk.name_length;
      end
      walk_start = '0;
      walk_count = 11'(ROOT_COUNT);
      walk_in_big = 1'b0;
      walk_failed = 1'b0;
      return 1'b1;
    end
    if (!walk_failed) begin
      if (hit < 0 || lk.child_count == '0) begin
        walk_failed = 1'b1;
      end else begin
        walk_start = lk.child_start;
        walk_count = lk.child_count;
        walk_in_big = lk.child_in_big;
      end
    end
    return 1'b0;
  endfunction

  function automatic void store_entry(input item_t it);
    link_t lk;
    lk.name_length = it.nlen;
    lk.name_offset = it.noff;
    lk.child_in_big = it.cbig;
    lk.child_count = it.ccount;
    lk.child_start = it.cstart;
    if (it.opcode == OP_WR_SMALL) begin
      small_keys[it.index] = it.key;
      small_links[it.index] = lk;
      small_written[it.index] = 1'b1;
    end else begin
      big_keys[it.index] = it.key;
      big_links[it.index] = lk;
      big_written[it.index] = 1'b1;
    end
    writes_sent++;
  endfunction

  function automatic item_t random_entry(input logic [1:0] op, input logic [9:0] idx);
    item_t it;
    int sel;
    int cnt;
    sel = $urandom_range(99);
    if (sel < 30) cnt = 0;
    else if (sel < 75) cnt = $urandom_range(5, 1);
    else if (sel < 95) cnt = $urandom_range(16, 6);
    else if (sel < 98) cnt = $urandom_range(1023, 17);
    else cnt = 1024;
    it.opcode = op;
    it.index = idx;
    it.key = $urandom;
    it.cstart = 10'($urandom);
    it.ccount = 11'(cnt);
    it.cbig = 1'($urandom);
    it.noff = 16'($urandom);
    it.nlen = 8'($urandom);
    it.last = 1'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] pick_lookup_key();
    int n;
    int sel;
    int idx;
    n = range_length();
    sel = $urandom_range(99);
    if (sel < 5) return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
    if (sel < 12 || n <= 0) return $urandom;
    idx = int'(walk_start) + int'($urandom_range(n - 1));
    if (!(walk_in_big ? big_written[idx] : small_written[idx])) return $urandom;
    if (sel < 20) return (walk_in_big ? big_keys[idx] : small_keys[idx]) + 32'd1;
    if (sel < 26) return (walk_in_big ? big_keys[idx] : small_keys[idx]) - 32'd1;
    return walk_in_big ? big_keys[idx] : small_keys[idx];
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      error_count++;
    end
  endfunction

  task automatic transfer_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {opcode_i, entry_index_i, key_value_i, child_start_i, child_count_i, child_in_big_i,
     name_offset_in_i, name_length_in_i, last_component_i} <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (it.opcode != OP_UNUSED) items_sent++;
  endtask

  // Write every entry the next search would read unwritten; fall back to key zero if deep.
  task automatic cover_gaps(inout logic [31:0] key);
    int gap;
    int fills;
    item_t fill;
    fills = 0;
    if (walk_failed) return;
    forever begin
      void'(search_range(key, gap));
      if (gap < 0) return;
      fill = random_entry(walk_in_big ? OP_WR_BIG : OP_WR_SMALL, 10'(gap));
      fill.key = {10'(gap), 22'($urandom)};
      store_entry(fill);
      transfer_item(fill);
      fills++;
      if (fills >= FILL_CAP) key = '0;
    end
  endtask

  task automatic commit_item(input item_t it, input logic typed, input name_result_t typed_res);
    name_result_t res;
    logic [31:0] key;
    if (it.opcode == OP_LOOKUP) begin
      key = it.key;
      cover_gaps(key);
      it.key = key;
      lookups_sent++;
      if (walk_component(it.key, it.last, res)) pending_names.push_back(typed ? typed_res : res);
    end else if (it.opcode != OP_UNUSED) begin
      store_entry(it);
    end
    transfer_item(it);
  endtask

  initial begin
    item_t it;
    int sel;
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 84;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[r]) commit_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].res);
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      if (items_sent >= DIRECTED_ITEMS + 2 * PHASE_ITEMS) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= DIRECTED_ITEMS + PHASE_ITEMS) begin
        send_idle_pct = 84;
        recv_idle_pct = 18;
      end
      if (!paused && items_sent >= 300) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_names.size() != 0) @(posedge clk_i);
      end
      if (!held && items_sent >= DIRECTED_ITEMS + 2 * PHASE_ITEMS + 20) begin
        held = 1'b1;
        hold_off_left <= HOLD_OFF_CYCLES;
      end
      sel = $urandom_range(99);
      if (sel < 4) begin
        it = random_entry(OP_UNUSED, 10'($urandom));
      end else if (sel < 24) begin
        it = random_entry($urandom_range(1) ? OP_WR_SMALL : OP_WR_BIG, 10'($urandom));
      end else begin
        it = random_entry(OP_LOOKUP, 10'($urandom));
        it.key = pick_lookup_key();
        it.last = $urandom_range(99) < (walk_failed ? 60 : 30);
      end
      commit_item(it, 1'b0, NO_NAME);
    end
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_names.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d transfers: %0d lookup components, %0d table writes; checked %0d results.",
             items_sent, lookups_sent, writes_sent, results_seen);
    $display("Idling mixes 18/84, 84/18 and none, plus a long output hold-off and a drain pause.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_names.size() == 0) begin
        $display("%0t: result with none expected: status %0b offset %0h length %0h",
                 $time, status_o, name_offset_o, name_length_o);
        error_count++;
      end else begin
        oldest_name = pending_names.pop_front();
        check_field("status", 32'(oldest_name.status), 32'(status_o));
        check_field("name_offset", 32'(oldest_name.name_offset), 32'(name_offset_o));
        check_field("name_length", 32'(oldest_name.name_length), 32'(name_length_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_names.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/oid_tn_pkg.sv
rtl/oid_tn_ram.sv
rtl/oid_tn_search.sv
rtl/oid_tree_name_lookup.sv
test/oid_tree_name_lookup_tb.sv
